// ===== rtl/connection_table_receiver_assert.svh =====
// Assertion macros used by the connection table receiver top level.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef CONNECTION_TABLE_RECEIVER_ASSERT_SVH
`define CONNECTION_TABLE_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define CRX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CRX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/crx_pkg.sv =====
// Types and constants for the connection table receiver.
// No dependencies; used by crx_core and the top level.
`default_nettype none

package crx_pkg;

    typedef enum logic [2:0] {
        CMD_CONNECT = 3'd0,
        CMD_ACK     = 3'd1,
        CMD_DATA    = 3'd2,
        CMD_FIN     = 3'd3,
        CMD_CLOSE   = 3'd4,
        CMD_CACK    = 3'd5,
        CMD_OTHER   = 3'd6
    } cmd_e;

    typedef enum logic [2:0] {
        KIND_NONE        = 3'd0,
        KIND_CONNECT_ACK = 3'd1,
        KIND_ACK         = 3'd2,
        KIND_REFUSED     = 3'd3,
        KIND_DISCARD     = 3'd4,
        KIND_ACK_SEEN    = 3'd5,
        KIND_CACK_SEEN   = 3'd6,
        KIND_UNKNOWN     = 3'd7
    } kind_e;

    typedef enum logic [1:0] {
        MODE_CLOSED    = 2'd0,
        MODE_CONNECTED = 2'd1,
        MODE_FIN       = 2'd2
    } mode_e;

    typedef enum logic [1:0] {
        REG_MAX_CONN     = 2'd0,
        REG_LOCAL_MTU    = 2'd1,
        REG_HEADER_BYTES = 2'd2
    } cfg_reg_e;

    localparam logic [4:0]  MAX_CONN_RESET     = 5'd16;
    localparam logic [15:0] LOCAL_MTU_RESET    = 16'd1500;
    localparam logic [7:0]  HEADER_BYTES_RESET = 8'd20;

    // Connection ids in the header are 4 bits, so at most 16 table rows are addressable.
    localparam int CONN_IDS = 16;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  src_node;
        logic [3:0]  conn_index;
        logic [15:0] seq_field;
        logic [3:0]  sender_tag;
        logic [15:0] window_field;
    } item_t;

    typedef struct packed {
        kind_e       kind;
        logic [7:0]  node;
        logic [3:0]  conn;
        logic [15:0] seq;
        logic [3:0]  sender;
        logic [15:0] window;
        logic        deliver;
        logic [31:0] deliver_len;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/connection_table_receiver.sv =====
// Connection table receiver, top level: config registers, header register, result register.
// Depends on crx_pkg, crx_core (with crx_alloc) and connection_table_receiver_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one decoded transport header per request:
//   cmd, src_node, conn_index, seq_field, sender_tag, window_field.
//   Output channel (out_valid/out_ready) returns exactly one result per header:
//   reply_kind and the reply fields, plus deliver/deliver_len for a FIN on a connected entry.
//   Config port: cfg_we with cfg_index 0 = connection slot limit, 1 = local_mtu,
//   2 = header_bytes; write only while no request is in flight.
//   Path: an accepted header is held in the header register, then decision logic
//   and the table update feed the result register.
//   Throughput: one header per cycle unless a held result stalls the header register;
//   the connection table is read and updated in the same cycle the header moves into the result register.
//   Reset: table cleared (all slots free and closed, counts zero), registers
//   return to 16 connections, MTU 1500, header size 20.
//   Receiver stall: result and pending header hold; in_ready drops once both
//   registers are full and out_ready is low.
`default_nettype none

`include "connection_table_receiver_assert.svh"

module connection_table_receiver #(
    parameter int SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  src_node,
    input  wire logic [3:0]  conn_index,
    input  wire logic [15:0] seq_field,
    input  wire logic [3:0]  sender_tag,
    input  wire logic [15:0] window_field,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       reply_kind,
    output logic [7:0]       reply_node,
    output logic [3:0]       reply_conn,
    output logic [15:0]      reply_seq,
    output logic [3:0]       reply_sender,
    output logic [15:0]      reply_window,
    output logic             deliver,
    output logic [31:0]      deliver_len,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [4:0]  max_conn_reg;
    logic [15:0] local_mtu_reg;
    logic [7:0]  header_bytes_reg;

    logic             hdr_valid_reg;
    crx_pkg::item_t   hdr_reg;
    logic             res_valid_reg;
    crx_pkg::result_t res_reg;
    crx_pkg::result_t res_next;
    logic             advance;

    assign advance  = hdr_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !hdr_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_conn_reg     <= crx_pkg::MAX_CONN_RESET;
            local_mtu_reg    <= crx_pkg::LOCAL_MTU_RESET;
            header_bytes_reg <= crx_pkg::HEADER_BYTES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                crx_pkg::REG_MAX_CONN:     max_conn_reg     <= cfg_data[4:0];
                crx_pkg::REG_LOCAL_MTU:    local_mtu_reg    <= cfg_data;
                crx_pkg::REG_HEADER_BYTES: header_bytes_reg <= cfg_data[7:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                hdr_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                hdr_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hdr_reg.cmd          <= cmd;
            hdr_reg.src_node     <= src_node;
            hdr_reg.conn_index   <= conn_index;
            hdr_reg.seq_field    <= seq_field;
            hdr_reg.sender_tag   <= sender_tag;
            hdr_reg.window_field <= window_field;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    crx_core #(
        .SLOTS (SLOTS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .item         (hdr_reg),
        .max_conn     (max_conn_reg),
        .local_mtu    (local_mtu_reg),
        .header_bytes (header_bytes_reg),
        .result       (res_next)
    );

    assign out_valid    = res_valid_reg;
    assign reply_kind   = res_reg.kind;
    assign reply_node   = res_reg.node;
    assign reply_conn   = res_reg.conn;
    assign reply_seq    = res_reg.seq;
    assign reply_sender = res_reg.sender;
    assign reply_window = res_reg.window;
    assign deliver      = res_reg.deliver;
    assign deliver_len  = res_reg.deliver_len;

    `CRX_ASSERT_NOW(a_stall_only_when_full, !in_ready,
        hdr_valid_reg && res_valid_reg && !out_ready, "input stalled without full pipeline")
    `CRX_ASSERT_NEXT(a_advance_loads_result, advance,
        res_valid_reg, "header advanced but no result presented")
    `CRX_ASSERT_NOW(a_deliver_is_ack, res_valid_reg && res_reg.deliver,
        res_reg.kind == crx_pkg::KIND_ACK, "deliver on a non-ack result")
    `CRX_ASSERT_NOW(a_len_only_on_deliver, res_valid_reg && !res_reg.deliver,
        res_reg.deliver_len == 32'd0, "byte count without deliver")

endmodule

`default_nettype wire

// ===== rtl/crx_alloc.sv =====
// Lowest-free-slot priority encoder for CONNECT, limited to slots below max_conn.
// Depends on nothing but its ports; instantiated by crx_core.
`default_nettype none

module crx_alloc #(
    parameter int SLOTS = 16,
    parameter int SIW   = 4
) (
    input  wire logic [SLOTS-1:0] busy,
    input  wire logic [4:0]       max_conn,
    output logic                  found,
    output logic [SIW-1:0]        idx
);

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        // scan downward so the lowest eligible slot wins
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy[i] && (i < int'(max_conn)))
            begin
                found = 1'b1;
                idx   = SIW'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/crx_core.sv =====
// Connection table and per-header decision logic (one header per call).
// Depends on crx_pkg and crx_alloc.
`default_nettype none

module crx_core #(
    parameter int SLOTS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire crx_pkg::item_t    item,
    input  wire logic [4:0]        max_conn,
    input  wire logic [15:0]       local_mtu,
    input  wire logic [7:0]        header_bytes,
    output crx_pkg::result_t       result
);

    localparam int TBL = (SLOTS < crx_pkg::CONN_IDS) ? SLOTS : crx_pkg::CONN_IDS;
    localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TIW = (TBL > 1) ? $clog2(TBL) : 1;

    crx_pkg::mode_e mode_reg  [TBL];
    logic [15:0]    seq_reg   [TBL];
    logic [31:0]    bytes_reg [TBL];
    logic [SLOTS-1:0] busy_reg;

    logic           alloc_found;
    logic [SIW-1:0] alloc_idx;
    logic           alloc_tbl;

    logic [TIW-1:0] tidx;
    logic [SIW-1:0] bidx;
    logic           in_table;
    crx_pkg::mode_e cur_mode;
    logic [15:0]    cur_seq;
    logic [31:0]    cur_bytes;
    logic [15:0]    seq_plus1;
    logic [32:0]    sum;
    logic [31:0]    sat_bytes;

    logic [9:0]         hb3;
    logic signed [17:0] mine;
    logic signed [17:0] req;
    logic signed [17:0] win_min;
    logic [15:0]        negotiated;

    logic alloc_we;
    logic data_we;
    logic clr_we;
    logic fin_we;
    logic close_we;

    crx_alloc #(
        .SLOTS (SLOTS),
        .SIW   (SIW)
    ) u_alloc (
        .busy     (busy_reg),
        .max_conn (max_conn),
        .found    (alloc_found),
        .idx      (alloc_idx)
    );

    assign alloc_tbl = int'(alloc_idx) < TBL;
    assign tidx      = item.conn_index[TIW-1:0];
    assign bidx      = SIW'(item.conn_index);
    assign in_table  = int'(item.conn_index) < TBL;
    assign cur_mode  = mode_reg[tidx];
    assign cur_seq   = seq_reg[tidx];
    assign cur_bytes = bytes_reg[tidx];
    assign seq_plus1 = cur_seq + 16'd1;
    assign sum       = {1'b0, cur_bytes} + {17'd0, item.window_field};
    assign sat_bytes = sum[32] ? '1 : sum[31:0];

    // window = max(0, min(mtu - 3*hdr, requested)), signed compare
    assign hb3        = {2'b00, header_bytes} + {1'b0, header_bytes, 1'b0};
    assign mine       = $signed({2'b00, local_mtu}) - $signed({8'd0, hb3});
    assign req        = $signed({2'b00, item.window_field});
    assign win_min    = (mine < req) ? mine : req;
    assign negotiated = win_min[17] ? 16'd0 : win_min[15:0];

    always_comb
    begin
        result      = '0;
        result.kind = crx_pkg::KIND_NONE;
        result.node = item.src_node;
        alloc_we    = 1'b0;
        data_we     = 1'b0;
        clr_we      = 1'b0;
        fin_we      = 1'b0;
        close_we    = 1'b0;
        case (item.cmd)
            crx_pkg::CMD_CONNECT:
            begin
                if (alloc_found)
                begin
                    alloc_we      = 1'b1;
                    result.kind   = crx_pkg::KIND_CONNECT_ACK;
                    result.conn   = 4'(alloc_idx);
                    result.sender = item.sender_tag;
                    result.window = negotiated;
                end
                else
                begin
                    result.kind = crx_pkg::KIND_REFUSED;
                end
            end
            crx_pkg::CMD_ACK:
            begin
                result.kind   = crx_pkg::KIND_ACK_SEEN;
                result.conn   = item.conn_index;
                result.seq    = item.seq_field;
                result.sender = item.sender_tag;
            end
            crx_pkg::CMD_DATA:
            begin
                if (!in_table)
                begin
                    result.kind = crx_pkg::KIND_DISCARD;
                end
                else if (item.seq_field == seq_plus1)
                begin
                    data_we       = 1'b1;
                    result.kind   = crx_pkg::KIND_ACK;
                    result.seq    = item.seq_field;
                    result.sender = item.sender_tag;
                end
                else if (item.seq_field == cur_seq)
                begin
                    // duplicate: ack again, count unchanged
                    result.kind   = crx_pkg::KIND_ACK;
                    result.seq    = item.seq_field;
                    result.sender = item.sender_tag;
                end
                else
                begin
                    result.kind = crx_pkg::KIND_DISCARD;
                end
            end
            crx_pkg::CMD_FIN:
            begin
                if (in_table)
                begin
                    if (cur_mode == crx_pkg::MODE_CONNECTED)
                    begin
                        clr_we             = 1'b1;
                        result.deliver     = 1'b1;
                        result.deliver_len = cur_bytes;
                    end
                    else
                    begin
                        fin_we = 1'b1;
                    end
                end
                result.kind   = crx_pkg::KIND_ACK;
                result.sender = item.sender_tag;
            end
            crx_pkg::CMD_CLOSE:
            begin
                close_we = in_table;
            end
            crx_pkg::CMD_CACK:
            begin
                result.kind   = crx_pkg::KIND_CACK_SEEN;
                result.conn   = item.conn_index;
                result.seq    = item.seq_field;
                result.sender = item.sender_tag;
                result.window = item.window_field;
            end
            default:
            begin
                result.kind = crx_pkg::KIND_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            for (int i = 0; i < TBL; i++)
            begin
                mode_reg[i]  <= crx_pkg::MODE_CLOSED;
                seq_reg[i]   <= '0;
                bytes_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            if (alloc_we)
            begin
                busy_reg[alloc_idx] <= 1'b1;
                // slots above the addressable range only track occupancy
                if (alloc_tbl)
                begin
                    mode_reg[alloc_idx[TIW-1:0]]  <= crx_pkg::MODE_CONNECTED;
                    seq_reg[alloc_idx[TIW-1:0]]   <= '0;
                    bytes_reg[alloc_idx[TIW-1:0]] <= '0;
                end
            end
            if (data_we)
            begin
                bytes_reg[tidx] <= sat_bytes;
                seq_reg[tidx]   <= item.seq_field;
            end
            if (clr_we)
            begin
                bytes_reg[tidx] <= '0;
            end
            if (fin_we)
            begin
                mode_reg[tidx] <= crx_pkg::MODE_FIN;
            end
            if (close_we)
            begin
                mode_reg[tidx] <= crx_pkg::MODE_CLOSED;
                busy_reg[bidx] <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
